/* sv/mbps_pkg.sv */
// Shared constants and types of the masked byte pattern scanner.
`default_nettype none
package mbps_pkg;

   localparam int MaxPatternBytes = 16;
   localparam int OffsetBits      = 32;
   localparam int ByteBits        = 8;
   localparam int OffsetOutBits   = 32;
   localparam int LenBits         = $clog2(MaxPatternBytes + 1);
   localparam int CsrDataBits     = 64;
   localparam int CsrIndexBits    = 3;
   localparam int LaneIdxBits     = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_MASK_LOW     = 3'd2,
      CSR_MASK_HIGH    = 3'd3,
      CSR_PATTERN_LEN  = 3'd4
   } csr_index_type;

   typedef logic [MaxPatternBytes-1:0][ByteBits-1:0] lanes_type;

   typedef struct packed {
      lanes_type          pattern;
      lanes_type          mask;
      logic [LenBits-1:0] length;   // already clamped to 1..MaxPatternBytes
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      lanes_type             window;  // entry 0 newest, after the shift
      logic [LenBits-1:0]    fill;
      logic [OffsetBits-1:0] seen;
   } scan_type;

endpackage
`default_nettype wire

/* sv/mbps_req_if.sv */
// Input channel: one scanned byte per transfer.
`default_nettype none
interface mbps_req_if;
   import mbps_pkg::*;
   logic                valid;
   logic                ready;
   logic [ByteBits-1:0] data_byte;
   logic                last_in_region;

   modport source (output valid, data_byte, last_in_region, input ready);
   modport sink (input valid, data_byte, last_in_region, output ready);
endinterface
`default_nettype wire

/* sv/mbps_rsp_if.sv */
// Result channel: offset of a found match.
`default_nettype none
interface mbps_rsp_if;
   import mbps_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OffsetOutBits-1:0] match_offset;

   modport source (output valid, match_offset, input ready);
   modport sink (input valid, match_offset, output ready);
endinterface
`default_nettype wire

/* sv/masked_byte_pattern_scan.sv */
// Top level of the masked byte pattern scanner.
//
// Bytes of a memory region enter on req, one per transfer, with last_in_region
// marking the final byte. The block keeps the newest sixteen bytes and the
// region offset; when the newest pattern_length bytes match the pattern under
// the per-byte masks (a zero mask byte over a zero pattern byte is a wildcard),
// a transfer on rsp carries the region offset of the first byte of the match.
// Overlapping matches and a match ending on the final byte are all reported.
// Configuration goes through csr_we / csr_index / csr_wdata; the user must
// write it only while idle, which the block itself does not enforce.
// A byte is registered at the input, then shifted and compared into the result
// register, which holds it while rsp stalls and offers it on rsp.
// The block takes one byte per cycle while rsp does not stall; the window
// shifts and all sixteen lanes compare for each byte.
// Reset (synchronous) clears the window, offset, fill, valid flags and CSRs (length 1).
// When rsp stalls with a result held, the input register holds one more byte and
// req.ready drops until the result is taken.
`default_nettype none
module masked_byte_pattern_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mbps_req_if.sink                               req,
   mbps_rsp_if.source                             rsp,
   input  wire logic                              csr_we,
   input  wire logic [mbps_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [mbps_pkg::CsrDataBits-1:0]  csr_wdata
);
   import mbps_pkg::*;

   cfg_type                  cfg;
   scan_type                 scan;
   logic                     busy, take, advance, hit;
   logic [OffsetOutBits-1:0] offset;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OffsetOutBits-1:0] rsp_offset_ff, rsp_offset_in;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !busy || advance;
   assign take      = req.valid && req.ready;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbps_window u_window (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .advance        (advance),
      .data_byte      (req.data_byte),
      .last_in_region (req.last_in_region),
      .busy           (busy),
      .scan           (scan)
   );

   mbps_compare u_compare (
      .cfg          (cfg),
      .scan         (scan),
      .hit          (hit),
      .match_offset (offset)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      if (advance) begin
         rsp_valid_in  = scan.valid && hit;
         rsp_offset_in = offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.match_offset = rsp_offset_ff;

endmodule
`default_nettype wire

/* sv/mbps_csr.sv */
// Configuration registers: pattern, masks and clamped pattern length.
`default_nettype none
module mbps_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [mbps_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [mbps_pkg::CsrDataBits-1:0]  csr_wdata,
   output mbps_pkg::cfg_type                      cfg
);
   import mbps_pkg::*;

   logic [CsrDataBits-1:0] pat_lo_ff, pat_lo_in, pat_hi_ff, pat_hi_in;
   logic [CsrDataBits-1:0] msk_lo_ff, msk_lo_in, msk_hi_ff, msk_hi_in;
   logic [LenBits-1:0]     len_ff, len_in;
   lanes_type              pat_all, msk_all;

   always_comb begin
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      msk_lo_in = msk_lo_ff;
      msk_hi_in = msk_hi_ff;
      len_in    = len_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pat_lo_in = csr_wdata;
            CSR_PATTERN_HIGH: pat_hi_in = csr_wdata;
            CSR_MASK_LOW:     msk_lo_in = csr_wdata;
            CSR_MASK_HIGH:    msk_hi_in = csr_wdata;
            CSR_PATTERN_LEN:  len_in    = csr_wdata[LenBits-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         msk_lo_ff <= '0;
         msk_hi_ff <= '0;
         len_ff    <= LenBits'(1);
      end else begin
         pat_lo_ff <= pat_lo_in;
         pat_hi_ff <= pat_hi_in;
         msk_lo_ff <= msk_lo_in;
         msk_hi_ff <= msk_hi_in;
         len_ff    <= len_in;
      end
   end

   always_comb begin
      pat_all = {pat_hi_ff, pat_lo_ff};
      msk_all = {msk_hi_ff, msk_lo_ff};
      cfg.pattern = pat_all;
      cfg.mask    = msk_all;
      // clamp the length to 1..MaxPatternBytes
      if (len_ff == '0) begin
         cfg.length = LenBits'(1);
      end else if (len_ff > LenBits'(MaxPatternBytes)) begin
         cfg.length = LenBits'(MaxPatternBytes);
      end else begin
         cfg.length = len_ff;
      end
   end

endmodule
`default_nettype wire

/* sv/mbps_window.sv */
// Input register, byte window, window fill and region offset.
`default_nettype none
module mbps_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic                          advance,
   input  wire logic [mbps_pkg::ByteBits-1:0] data_byte,
   input  wire logic                          last_in_region,
   output logic                               busy,
   output mbps_pkg::scan_type                 scan
);
   import mbps_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [ByteBits-1:0]   in_byte_ff, in_byte_in;
   logic                  in_last_ff, in_last_in;
   lanes_type             window_ff, window_in, shifted;
   logic [LenBits-1:0]    fill_ff, fill_in, fill_next;
   logic [OffsetBits-1:0] seen_ff, seen_in, seen_next;
   logic                  step;

   assign step = in_valid_ff && advance;
   assign busy = in_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      in_byte_in = take ? data_byte : in_byte_ff;
      in_last_in = take ? last_in_region : in_last_ff;
   end

   always_comb begin
      shifted = {window_ff[MaxPatternBytes-2:0], in_byte_ff};
      fill_next = (fill_ff < LenBits'(MaxPatternBytes)) ? fill_ff + LenBits'(1) : fill_ff;
      seen_next = seen_ff + OffsetBits'(1);
      window_in = window_ff;
      fill_in   = fill_ff;
      seen_in   = seen_ff;
      if (step) begin
         // clear the window after the final byte of a region
         if (in_last_ff) begin
            window_in = '0;
            fill_in   = '0;
            seen_in   = '0;
         end else begin
            window_in = shifted;
            fill_in   = fill_next;
            seen_in   = seen_next;
         end
      end
      scan.valid  = step;
      scan.window = shifted;
      scan.fill   = fill_next;
      scan.seen   = seen_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         window_ff   <= '0;
         fill_ff     <= '0;
         seen_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         window_ff   <= window_in;
         fill_ff     <= fill_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

endmodule
`default_nettype wire

/* sv/mbps_compare.sv */
// Parallel masked compare of the window against the pattern.
`default_nettype none
module mbps_compare (
   input  wire mbps_pkg::cfg_type                  cfg,
   input  wire mbps_pkg::scan_type                 scan,
   output logic                                    hit,
   output logic [mbps_pkg::OffsetOutBits-1:0]      match_offset
);
   import mbps_pkg::*;

   logic [MaxPatternBytes-1:0] lane_ok;
   logic [LaneIdxBits-1:0]     lane_sel;
   logic [OffsetBits-1:0]      start;

   // window entry k holds pattern byte (length - 1 - k)
   always_comb begin
      for (int k = 0; k < MaxPatternBytes; k++) begin
         lane_sel = LaneIdxBits'(cfg.length - LenBits'(1) - LenBits'(k));
         if (LenBits'(k) < cfg.length) begin
            lane_ok[k] = ((scan.window[k] & cfg.mask[lane_sel]) == cfg.pattern[lane_sel]);
         end else begin
            lane_ok[k] = 1'b1;
         end
      end
      hit = (scan.fill >= cfg.length) && (&lane_ok);
      start = scan.seen - OffsetBits'(cfg.length);
      match_offset = start[OffsetOutBits-1:0];
   end

endmodule
`default_nettype wire

/* sim/masked_byte_pattern_scan_tb.sv */
// Self-checking testbench for the masked byte pattern scanner: predicts match offsets per byte.
`timescale 1ns / 100ps

import mbps_pkg::*;

// Tracks the scan window and region offset, and queues the match offsets they imply.
class match_ledger;
   lanes_type                pattern;
   lanes_type                mask;
   logic [LenBits-1:0]       length_code;
   lanes_type                window;
   int                       fill;
   logic [OffsetBits-1:0]    seen;
   logic [OffsetOutBits-1:0] expected_offsets[$];
   int                       errors;

   function new();
      pattern     = '0;
      mask        = '0;
      length_code = LenBits'(1);
      window      = '0;
      fill        = 0;
      seen        = '0;
      errors      = 0;
   endfunction

   function int active_length();
      int n;
      n = int'(length_code);
      if (n < 1) n = 1;
      if (n > MaxPatternBytes) n = MaxPatternBytes;
      return n;
   endfunction

   function void write_reg(logic [CsrIndexBits-1:0] index, logic [CsrDataBits-1:0] value);
      case (index)
         CSR_PATTERN_LOW:  pattern[7:0]  = value;
         CSR_PATTERN_HIGH: pattern[15:8] = value;
         CSR_MASK_LOW:     mask[7:0]     = value;
         CSR_MASK_HIGH:    mask[15:8]    = value;
         CSR_PATTERN_LEN:  length_code   = value[LenBits-1:0];
         default: ;
      endcase
   endfunction

   function void take_byte(logic [ByteBits-1:0] value, logic last);
      int  len;
      bit  hit;
      window = {window[MaxPatternBytes-2:0], value};
      if (fill < MaxPatternBytes) fill++;
      seen++;
      len = active_length();
      if (fill >= len) begin
         hit = 1'b1;
         // lane 0 is the oldest byte of the candidate match
         for (int i = 0; i < len; i++)
            if ((window[len-1-i] & mask[i]) != pattern[i]) hit = 1'b0;
         if (hit)
            expected_offsets = {expected_offsets,
                                OffsetOutBits'(seen - OffsetBits'(len))};
      end
      if (last) begin
         window = '0;
         fill   = 0;
         seen   = '0;
      end
   endfunction

   function void check_match(logic [OffsetOutBits-1:0] got);
      logic [OffsetOutBits-1:0] want;
      if (expected_offsets.size() == 0) begin
         $error("match_offset: expected no result, got %0d", got);
         errors++;
      end else begin
         want = expected_offsets.pop_front();
         if (got !== want) begin
            $error("match_offset: expected %0d, got %0d", want, got);
            errors++;
         end
      end
   endfunction

   function int pending();
      return expected_offsets.size();
   endfunction
endclass

module masked_byte_pattern_scan_tb;

   localparam int SettleCycles = 6;
   localparam int RandomPhases = 10;
   localparam int PhaseItems   = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_we    = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0]  csr_wdata = '0;

   int req_gap_max = 0;
   int rsp_gap_max = 0;
   int items_sent  = 0;

   match_ledger ledger = new();

   mbps_req_if req_ch ();
   mbps_rsp_if rsp_ch ();

   masked_byte_pattern_scan DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.data_byte      = '0;
      req_ch.last_in_region = 1'b0;
      rsp_ch.ready          = 1'b0;
   end

   // All driver tasks start and finish on a falling edge.
   task automatic write_csr(input logic [CsrIndexBits-1:0] index,
                            input logic [CsrDataBits-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      ledger.write_reg(index, value);
      @(negedge clock);
   endtask

   task automatic write_spares(input logic [CsrDataBits-1:0] value);
      for (int idx = int'(CSR_PATTERN_LEN) + 1; idx < (1 << CsrIndexBits); idx++)
         write_csr(CsrIndexBits'(idx), value);
   endtask

   task automatic send_byte(input logic [ByteBits-1:0] value, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= value;
      req_ch.last_in_region <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      ledger.take_byte(value, last);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted match has been taken.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      csr_we       <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic pick_config(input int phase);
      lanes_type                pat;
      lanes_type                msk;
      logic [LenBits-1:0]       len_code;
      logic [CsrDataBits-1:0]   word;
      int                       sel;
      for (int lane = 0; lane < MaxPatternBytes; lane++) begin
         sel = $urandom_range(0, 3);
         msk[lane] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hff : ByteBits'($urandom_range(0, 255));
         pat[lane] = ByteBits'($urandom_range(0, 255)) & msk[lane];
      end
      if (phase == 0) begin
         msk      = '1;
         pat      = {$urandom(), $urandom(), $urandom(), $urandom()};
         len_code = LenBits'(MaxPatternBytes);
      end else if (phase == 1) begin
         len_code = LenBits'(1);
      end else begin
         sel = $urandom_range(0, 9);
         if (sel == 0)      len_code = '0;
         else if (sel == 1) len_code = LenBits'($urandom_range(MaxPatternBytes + 1, 31));
         else               len_code = LenBits'($urandom_range(1, MaxPatternBytes));
         // occasionally a pattern bit falls outside its mask: no match can occur
         if ($urandom_range(0, 7) == 0) begin
            msk[0] = 8'h0f;
            pat[0] = 8'hf0 | ByteBits'($urandom_range(0, 255));
         end
      end
      write_csr(CSR_PATTERN_LOW, pat[7:0]);
      write_csr(CSR_PATTERN_HIGH, pat[15:8]);
      write_csr(CSR_MASK_LOW, msk[7:0]);
      write_csr(CSR_MASK_HIGH, msk[15:8]);
      word = {$urandom(), $urandom()};
      word[LenBits-1:0] = len_code;
      write_csr(CSR_PATTERN_LEN, word);
      if ($urandom_range(0, 2) == 0)
         write_csr(CsrIndexBits'($urandom_range(int'(CSR_PATTERN_LEN) + 1,
                                                (1 << CsrIndexBits) - 1)),
                   {$urandom(), $urandom()});
      csr_we <= 1'b0;
   endtask

   // Send a run of bytes that satisfies the pattern; a broken run flips one bit, if that bit is masked.
   task automatic send_signature(input bit broken);
      logic [ByteBits-1:0] value;
      int                  n;
      int                  bad_lane;
      n        = ledger.active_length();
      bad_lane = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
         value = (ledger.pattern[i] & ledger.mask[i])
               | (ByteBits'($urandom_range(0, 255)) & ~ledger.mask[i]);
         if (broken && i == bad_lane)
            value ^= (8'h01 << $urandom_range(0, 7)) & ledger.mask[i];
         send_byte(value, $urandom_range(0, 39) == 0);
      end
   endtask

   // Result side: stall a drawn number of cycles before each transfer.
   initial begin
      int gap;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
         ledger.check_match(rsp_ch.match_offset);
         @(negedge clock);
      end
   end

   initial begin
      int phase_start;
      int pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: length one, all wildcard, so every byte matches
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'h5a, 1'b0);
      wait_idle();

      // exact byte compare; length zero clamps to one; spare indexes ignored
      write_csr(CSR_PATTERN_LOW, 64'h0000_0000_0000_00a5);
      write_csr(CSR_MASK_LOW, 64'h0000_0000_0000_00ff);
      write_csr(CSR_PATTERN_LEN, '0);
      write_spares('1);
      csr_we <= 1'b0;
      send_byte(8'ha5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'ha5, 1'b1);
      wait_idle();

      // oversize length clamps to sixteen; nothing until the window fills
      write_csr(CSR_PATTERN_LOW, '0);
      write_csr(CSR_MASK_LOW, '0);
      write_csr(CSR_MASK_HIGH, '0);
      write_csr(CSR_PATTERN_LEN, 64'd31);
      csr_we <= 1'b0;
      for (int i = 0; i < MaxPatternBytes; i++)
         send_byte(ByteBits'($urandom_range(0, 255)), i == MaxPatternBytes - 1);
      wait_idle();

      // pattern bit outside its mask: never a match
      write_csr(CSR_PATTERN_LOW, 64'h0000_0000_0000_0001);
      write_csr(CSR_MASK_LOW, 64'h0000_0000_0000_00fe);
      write_csr(CSR_PATTERN_LEN, 64'd1);
      csr_we <= 1'b0;
      send_byte(8'h01, 1'b0);
      send_byte(8'hff, 1'b1);
      wait_idle();

      for (int phase = 0; phase < RandomPhases; phase++) begin
         pick_config(phase);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
         phase_start = items_sent;
         while (items_sent - phase_start < PhaseItems) begin
            pick = $urandom_range(0, 39);
            if (pick < 20)
               send_signature(1'b0);
            else if (pick < 25)
               send_signature(1'b1);
            else if (pick == 39)
               wait_idle();
            else
               repeat ($urandom_range(1, 4))
                  send_byte(ByteBits'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
         end
         wait_idle();
      end

      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
sv/mbps_pkg.sv
sv/mbps_req_if.sv
sv/mbps_rsp_if.sv
sv/mbps_csr.sv
sv/mbps_window.sv
sv/mbps_compare.sv
sv/masked_byte_pattern_scan.sv
sim/masked_byte_pattern_scan_tb.sv
